[hdl/slss_pkg.sv]
// Package: shared widths, types and divider request/response structs for the linear solver.
`timescale 1ns / 1ps
package slss_pkg;
    localparam int MAX_UNKNOWNS = 3;
    localparam int COEF_W = 16;
    localparam int ACC_W = 52;
    localparam int SOL_W = 48;
    localparam int QUOT_BITS = 48;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // divider request/response between sequencer and divider
    typedef struct packed {
        logic start;
        logic [ACC_W-1:0] num_mag;
        logic [ACC_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [QUOT_BITS:0] quot;
    } div_rsp_t;
endpackage

[hdl/slss_div.sv]
// Restoring divider: unsigned magnitudes into a Q32.16 quotient, one quotient bit per cycle.
`timescale 1ns / 1ps
module slss_div (
    input  logic                clk,
    input  logic                rst_n,
    input  slss_pkg::div_req_t  req,
    output slss_pkg::div_rsp_t  rsp
);
    import slss_pkg::*;

    localparam int STEPS = ACC_W + 16;

    logic [ACC_W+16-1:0] num_reg;
    logic [ACC_W:0]      rem_reg;
    logic [ACC_W-1:0]    den_reg;
    logic [STEPS-1:0]    quot_reg;
    logic [6:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ACC_W:0]      shifted;
    logic [ACC_W:0]      diff;

    always_comb
    begin
        shifted = {rem_reg[ACC_W-1:0], num_reg[ACC_W+16-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == 7'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(STEPS);
                num_reg  <= {req.num_mag, 16'd0};
                den_reg  <= req.den_mag;
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (!diff[ACC_W])
                begin
                    rem_reg  <= diff;
                    quot_reg <= {quot_reg[STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    quot_reg <= {quot_reg[STEPS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    // anything at or above 2^48 saturates anyway: fold into one overflow bit
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = {|quot_reg[STEPS-1:QUOT_BITS], quot_reg[QUOT_BITS-1:0]};

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");
    a_busy_counting: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 7'd0))
        else $error("divider busy with spent count");
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
endmodule

[hdl/small_linear_system_solver_top.sv]
// Top level: row store, sequencer with one shared multiplier, divider and output register.
// Sequence: a row without solve_now is taken directly. A solve first computes the
// determinant, then per unknown runs the multiply-accumulate steps, issues the division,
// waits for the divider and hands over the word; singular skips the divider.
// Throughput: one solve at a time; the input is not ready until all results are taken.
// Reset: asynchronous active low; system_size returns to 3, determinant to zero.
// Row stores have no reset and are undefined until written.
`timescale 1ns / 1ps
module small_linear_system_solver_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  row_index,
    input  slss_pkg::coef_t             coef_first,
    input  slss_pkg::coef_t             coef_second,
    input  slss_pkg::coef_t             coef_third,
    input  slss_pkg::coef_t             rhs_value,
    input  logic                        solve_now,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  unknown_index,
    output logic signed [47:0]          solution_value,
    output logic                        singular,
    output logic                        saturated,
    output logic                        last_result
);
    import slss_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    coef_t a_reg [3][3];
    coef_t b_reg [3];
    logic [1:0] size_reg;
    logic [2:0] state_reg;
    logic [1:0] n_reg;
    logic [1:0] sj_reg;
    logic [1:0] sp_reg;
    logic [1:0] unk_reg;
    acc_t det_reg;
    acc_t acc_reg;
    acc_t tmp_reg;
    logic det_phase_reg;
    logic neg_reg;

    // one multiplier: 32 x 16 signed covers cofactor times coefficient
    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic [1:0] mul_op;
    logic       mul_to_tmp;
    logic signed [47:0] mul_p;
    acc_t prod_ext;
    acc_t acc_new;
    acc_t tmp_new;
    coef_t cof_mult;
    logic [1:0] row_sel, col_sel;
    logic [1:0] ri1, ri2, ci1, ci2;
    logic [1:0] last_sj;
    logic last_step;

    div_req_t dreq;
    div_rsp_t drsp;

    slss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);

    function automatic logic [1:0] mod3(input logic [2:0] v);
        return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
    endfunction

    // sj walks the outer index, sp the three steps within it.
    // Determinant pass: sj is column k of row 0, cofactor rows 1 and 2.
    // Unknown pass: sj is row j, cofactor columns taken from the unknown.
    // Steps for three unknowns: tmp = a*a, tmp -= a*a, acc += tmp * (b[j] or a[0][k]).
    always_comb
    begin
        row_sel  = det_phase_reg ? 2'd0 : sj_reg;
        col_sel  = det_phase_reg ? sj_reg : unk_reg;
        ri1      = mod3(3'(row_sel) + 3'd1);
        ri2      = mod3(3'(row_sel) + 3'd2);
        ci1      = mod3(3'(col_sel) + 3'd1);
        ci2      = mod3(3'(col_sel) + 3'd2);
        cof_mult = det_phase_reg ? a_reg[0][sj_reg] : b_reg[sj_reg];
        mul_a      = '0;
        mul_b      = '0;
        mul_op     = OP_NONE;
        mul_to_tmp = 1'b0;
        if (n_reg == 2'd3)
        begin
            case (sp_reg)
                2'd0:
                begin
                    mul_a = 32'(a_reg[ri1][ci1]); mul_b = a_reg[ri2][ci2];
                    mul_op = OP_LOAD; mul_to_tmp = 1'b1;
                end
                2'd1:
                begin
                    mul_a = 32'(a_reg[ri1][ci2]); mul_b = a_reg[ri2][ci1];
                    mul_op = OP_SUB; mul_to_tmp = 1'b1;
                end
                default:
                begin
                    mul_a = tmp_reg[31:0]; mul_b = cof_mult;
                    mul_op = OP_ADD;
                end
            endcase
        end
        else if (n_reg == 2'd2)
        begin
            if (det_phase_reg)
            begin
                if (sp_reg == 2'd0)
                begin
                    mul_a = 32'(a_reg[0][0]); mul_b = a_reg[1][1]; mul_op = OP_ADD;
                end
                else if (sp_reg == 2'd1)
                begin
                    mul_a = 32'(a_reg[0][1]); mul_b = a_reg[1][0]; mul_op = OP_SUB;
                end
            end
            else if (sp_reg == 2'd0)
            begin
                // adj = [[a11,-a01],[-a10,a00]]
                mul_a  = (unk_reg == sj_reg) ? 32'(a_reg[sj_reg ^ 2'd1][sj_reg ^ 2'd1])
                                             : 32'(a_reg[unk_reg][sj_reg]);
                mul_b  = b_reg[sj_reg];
                mul_op = (unk_reg == sj_reg) ? OP_ADD : OP_SUB;
            end
        end
        else if (sp_reg == 2'd0 && sj_reg == 2'd0)
        begin
            mul_a = 32'sd1; mul_b = cof_mult; mul_op = OP_ADD;
        end
        mul_p    = mul_a * mul_b;
        prod_ext = ACC_W'(mul_p);
        acc_new  = acc_reg;
        tmp_new  = tmp_reg;
        unique case (mul_op)
            OP_LOAD: tmp_new = prod_ext;
            OP_ADD:
            begin
                if (mul_to_tmp) tmp_new = tmp_reg + prod_ext;
                else acc_new = acc_reg + prod_ext;
            end
            OP_SUB:
            begin
                if (mul_to_tmp) tmp_new = tmp_reg - prod_ext;
                else acc_new = acc_reg - prod_ext;
            end
            default:
            begin
                acc_new = acc_reg;
                tmp_new = tmp_reg;
            end
        endcase
        last_sj   = det_phase_reg ? ((n_reg == 2'd3) ? 2'd2 : 2'd0) : (n_reg - 2'd1);
        last_step = (sj_reg == last_sj) && (sp_reg == 2'd2);
    end

    logic [ACC_W-1:0] num_mag, den_mag;
    assign num_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign den_mag = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : det_reg;

    logic [QUOT_BITS:0] q;
    logic [SOL_W-1:0] pos_max, neg_mag;
    assign q = drsp.quot;
    assign pos_max = {1'b0, {(SOL_W-1){1'b1}}};
    assign neg_mag = {1'b1, {(SOL_W-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && row_index < 2'(MAX_UNKNOWNS))
        begin
            a_reg[row_index][0] <= coef_first;
            a_reg[row_index][1] <= coef_second;
            a_reg[row_index][2] <= coef_third;
            b_reg[row_index]    <= rhs_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= 2'd3;
            state_reg      <= ST_IDLE;
            n_reg          <= 2'd3;
            sj_reg         <= '0;
            sp_reg         <= '0;
            unk_reg        <= '0;
            det_reg        <= '0;
            acc_reg        <= '0;
            tmp_reg        <= '0;
            det_phase_reg  <= 1'b0;
            out_valid      <= 1'b0;
            neg_reg        <= 1'b0;
            dreq           <= '0;
            unknown_index  <= '0;
            solution_value <= '0;
            singular       <= 1'b0;
            saturated      <= 1'b0;
            last_result    <= 1'b0;
        end
        else
        begin
            dreq.start <= (state_reg == ST_DIV) && (det_reg != '0);
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && solve_now)
                    begin
                        n_reg <= (size_reg == 2'd0) ? 2'd1 : size_reg;
                        sj_reg <= '0;
                        sp_reg <= '0;
                        unk_reg <= '0;
                        acc_reg <= '0;
                        tmp_reg <= '0;
                        det_phase_reg <= 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    if (det_phase_reg && last_step)
                    begin
                        det_reg <= acc_new;
                        acc_reg <= '0;
                        det_phase_reg <= 1'b0;
                    end
                    else
                    begin
                        acc_reg <= acc_new;
                        tmp_reg <= tmp_new;
                    end
                    if (last_step)
                    begin
                        sj_reg <= '0;
                        sp_reg <= '0;
                        if (!det_phase_reg)
                            state_reg <= ST_DIV;
                    end
                    else if (sp_reg == 2'd2)
                    begin
                        sp_reg <= '0;
                        sj_reg <= sj_reg + 2'd1;
                    end
                    else
                        sp_reg <= sp_reg + 2'd1;
                end
                ST_DIV:
                begin
                    neg_reg <= (acc_reg[ACC_W-1] != det_reg[ACC_W-1]) && (acc_reg != '0);
                    if (det_reg != '0)
                    begin
                        dreq.num_mag <= num_mag;
                        dreq.den_mag <= den_mag;
                        state_reg    <= ST_WAIT;
                    end
                    else
                    begin
                        solution_value <= '0;
                        singular   <= 1'b1;
                        saturated  <= 1'b0;
                        unknown_index <= unk_reg;
                        last_result <= (unk_reg == n_reg - 2'd1);
                        out_valid  <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_WAIT:
                begin
                    if (drsp.done)
                    begin
                        singular <= 1'b0;
                        unknown_index <= unk_reg;
                        last_result <= (unk_reg == n_reg - 2'd1);
                        out_valid <= 1'b1;
                        state_reg <= ST_OUT;
                        if (!neg_reg)
                        begin
                            saturated <= (q > (QUOT_BITS+1)'(pos_max));
                            solution_value <= (q > (QUOT_BITS+1)'(pos_max)) ? pos_max
                                             : q[SOL_W-1:0];
                        end
                        else
                        begin
                            saturated <= (q > (QUOT_BITS+1)'(neg_mag));
                            solution_value <= (q > (QUOT_BITS+1)'(neg_mag)) ? neg_mag
                                             : SOL_W'(-q[SOL_W-1:0]);
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (last_result)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            unk_reg  <= unk_reg + 2'd1;
                            sj_reg   <= '0;
                            sp_reg   <= '0;
                            acc_reg  <= '0;
                            tmp_reg  <= '0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken during solve");
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_OUT))
        else $error("result shown outside output state");
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (solution_value == '0 && !saturated))
        else $error("singular result not zero");
endmodule
